>>> hdl/sfbc_pkg.sv
// Shared constants, types and state encodings for the SHA-1 Feistel cipher unit.
`default_nettype none

package sfbc_pkg;

    localparam int unsigned HalfW   = 16;
    localparam int unsigned KeyW    = 24;
    localparam int unsigned BlockW  = 32;
    localparam int unsigned WordW   = 32;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned StepW   = 7;
    localparam int unsigned NumW    = 16;

    localparam int unsigned DefRounds = 32;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_FIRST_KEY  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_KEY = 2'd1;

    // SHA-1 initial hash words.
    localparam logic [WordW-1:0] H0 = 32'h67452301;
    localparam logic [WordW-1:0] H1 = 32'hEFCDAB89;
    localparam logic [WordW-1:0] H2 = 32'h98BADCFE;
    localparam logic [WordW-1:0] H3 = 32'h10325476;
    localparam logic [WordW-1:0] H4 = 32'hC3D2E1F0;

    // SHA-1 step constants.
    localparam logic [WordW-1:0] K0 = 32'h5A827999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

    // Padding for a 40-bit message: the marker byte after the key and the bit length.
    localparam logic [23:0]      PAD_MARK = 24'h800000;
    localparam logic [WordW-1:0] MSG_BITS = 32'd40;

    localparam logic [StepW-1:0] STEP_B1   = 7'd20;
    localparam logic [StepW-1:0] STEP_B2   = 7'd40;
    localparam logic [StepW-1:0] STEP_B3   = 7'd60;
    localparam logic [StepW-1:0] STEP_LAST = 7'd79;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_FIN
    } t_core_state;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_START,
        TS_WAIT,
        TS_EMIT
    } t_top_state;

    // Request from the round sequencer to the hash core.
    typedef struct packed {
        logic             start;
        logic [HalfW-1:0] half;
        logic [KeyW-1:0]  key;
    } t_core_req;

    // Status from the hash core back to the sequencer.
    typedef struct packed {
        logic             done;
        logic [HalfW-1:0] result;
    } t_core_rsp;

endpackage

`default_nettype wire

>>> hdl/sha1_feistel_block_cipher_unit.sv
// Top level of the Feistel block cipher with a SHA-1 round function.
//
// The input channel carries one request per block: i_kind selects encryption
// (0) or decryption (1) and i_in_block holds the block, left half in the upper
// 16 bits. A request is taken when i_in_valid is high and o_in_stall is low.
// The unit then raises o_in_stall and works on that block alone.
// Each of the ROUNDS Feistel rounds runs one full SHA-1 compression on the
// shared hash core, one compression step per cycle. A round loads the message
// schedule, runs the 80 steps and then reads out the digest.
// The result is held in an output register. o_out_valid rises with o_out_block
// and stays with a stable value while i_out_stall is high. The unit may accept
// the next request while that result still waits; if its own result is ready
// before the old one is taken, it waits for the register. The two 24-bit key
// halves are written through the configuration channel (index 0 first half,
// index 1 second half); o_cfg_ready is always high. Writes to other indexes
// are dropped. The user must change the keys only while idle; the unit does
// not enforce this. Synchronous active-low reset clears the key halves, the
// sequencer and the output valid; the unit is ready for a request in the
// first cycle after it.
`default_nettype none

module sha1_feistel_block_cipher_unit
    import sfbc_pkg::*;
#(
    parameter int unsigned ROUNDS = DefRounds
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_kind,
    input  wire logic [BlockW-1:0]  i_in_block,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [BlockW-1:0]       o_out_block,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [KeyW-1:0]    i_cfg_data
);

    localparam int unsigned RndW = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;

    t_top_state r_state, n_state;

    logic [KeyW-1:0]  r_first_key_half, r_second_key_half;
    logic [HalfW-1:0] r_left, r_right;
    logic             r_decrypt;
    logic [RndW-1:0]  r_round;
    logic             r_out_valid;
    logic [BlockW-1:0] r_out_block;

    t_core_req core_req;
    t_core_rsp core_rsp;

    logic in_take, out_free, last_round, use_first;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_round = (r_round == RndW'(ROUNDS - 1));
    // Even rounds take the first half when encrypting; decryption reverses the order.
    assign use_first  = (!r_round[0]) != r_decrypt;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_block = r_out_block;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_key_half  <= '0;
            r_second_key_half <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FIRST_KEY:  r_first_key_half  <= i_cfg_data;
                CFG_SECOND_KEY: r_second_key_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Round sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE:  if (in_take) n_state = TS_START;
            TS_START: n_state = TS_WAIT;
            TS_WAIT: begin
                if (core_rsp.done) begin
                    n_state = last_round ? TS_EMIT : TS_START;
                end
            end
            TS_EMIT:  if (out_free) n_state = TS_IDLE;
            default:  n_state = TS_IDLE;
        endcase
    end

    // Round sequencer: outputs.
    always_comb begin
        o_in_stall     = (r_state != TS_IDLE);
        core_req.start = (r_state == TS_START);
        core_req.half  = r_right;
        core_req.key   = use_first ? r_first_key_half : r_second_key_half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == TS_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Block halves and round counter.
    always_ff @(posedge i_clk) begin
        if (r_state == TS_IDLE && in_take) begin
            r_left    <= i_in_block[BlockW-1:HalfW];
            r_right   <= i_in_block[HalfW-1:0];
            r_decrypt <= i_kind;
            r_round   <= '0;
        end else if (r_state == TS_WAIT && core_rsp.done) begin
            r_left  <= r_right;
            r_right <= r_left ^ core_rsp.result;
            if (!last_round) begin
                r_round <= r_round + RndW'(1);
            end
        end
        if (r_state == TS_EMIT && out_free) begin
            // The halves trade places once more on the way out.
            r_out_block <= {r_right, r_left};
        end
    end

    sfbc_sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_rsp   (core_rsp)
    );

endmodule

`default_nettype wire

>>> hdl/sfbc_sha1_core.sv
// Iterative SHA-1 compression core: one step per cycle over a 16-word schedule window.
`default_nettype none

module sfbc_sha1_core
    import sfbc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_core_req i_req,
    output t_core_rsp      o_rsp
);

    t_core_state r_state, n_state;
    logic [StepW-1:0] r_step;
    logic [WordW-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [WordW-1:0] r_w [NumW];

    logic [WordW-1:0] f_val, k_val, t_val, w_new, w_mix, digest_a;

    // The expanded word for step i+16 comes from the window taps i+13, i+8, i+2 and i.
    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new = {w_mix[WordW-2:0], w_mix[WordW-1]};

    always_comb begin
        if (r_step < STEP_B1) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K0;
        end else if (r_step < STEP_B2) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K1;
        end else if (r_step < STEP_B3) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K3;
        end
        t_val = {r_a[WordW-6:0], r_a[WordW-1:WordW-5]} + f_val + r_e + k_val + r_w[0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: if (i_req.start) n_state = CS_RUN;
            CS_RUN:  if (r_step == STEP_LAST) n_state = CS_FIN;
            CS_FIN:  n_state = CS_IDLE;
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        digest_a     = H0 + r_a;
        o_rsp.done   = (r_state == CS_FIN);
        o_rsp.result = digest_a[WordW-1:HalfW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == CS_RUN) begin
                r_step <= r_step + 7'd1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CS_IDLE && i_req.start) begin
            r_a <= H0;
            r_b <= H1;
            r_c <= H2;
            r_d <= H3;
            r_e <= H4;
            r_w[0] <= {i_req.half, i_req.key[KeyW-1:8]};
            r_w[1] <= {i_req.key[7:0], PAD_MARK};
            for (int j = 2; j < NumW - 1; j++) begin
                r_w[j] <= '0;
            end
            r_w[NumW-1] <= MSG_BITS;
        end else if (r_state == CS_RUN) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[WordW-1:2]};
            r_b <= r_a;
            r_a <= t_val;
            for (int j = 0; j < NumW - 1; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[NumW-1] <= w_new;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sfbc_checker.sv
// Port-level checker for the SHA-1 Feistel cipher unit and its bind statement.
`default_nettype none

module sfbc_checker
    import sfbc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [BlockW-1:0] o_out_block
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid set after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("unit not busy after taking a request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_block)))
        else $error("stalled result changed");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared right after a request");

endmodule

bind sha1_feistel_block_cipher_unit sfbc_checker u_sfbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_block (o_out_block)
);

`default_nettype wire
